[rtl/core/mmat_pkg.sv]
// Shared types and constants for the multichannel moving average core.
`timescale 1ns / 1ps

package mmat_pkg;

   localparam int CHANNEL_W   = 4;
   localparam int SAMPLE_BITS = 32;
   localparam int TREND_W     = 2;

   localparam int WIN_SIZE  = 5;
   localparam int WIN_SLOTS = 4;
   localparam int SLOT_W    = 2;
   localparam int FILL_W    = 3;

   // A sum of five samples needs three extra bits; the divider retires
   // DIV_STEP quotient bits per cycle.
   localparam int SUM_W      = SAMPLE_BITS + 3;
   localparam int DIV_STEP   = 7;
   localparam int DIV_CYCLES = SUM_W / DIV_STEP;

   localparam logic [TREND_W-1:0] TREND_EQUAL = 2'd0;
   localparam logic [TREND_W-1:0] TREND_ROSE  = 2'd1;
   localparam logic [TREND_W-1:0] TREND_FELL  = 2'd2;

   typedef struct packed {
      logic [CHANNEL_W-1:0]   channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0]   channel_out;
      logic [SAMPLE_BITS-1:0] latest;
      logic [SAMPLE_BITS-1:0] mean;
      logic [TREND_W-1:0]     sample_trend;
      logic [TREND_W-1:0]     mean_trend;
   } rsp_type;

   typedef struct packed {
      logic [FILL_W-1:0]      fill;
      logic [SLOT_W-1:0]      slot;
      logic [SAMPLE_BITS-1:0] last_sample;
      logic [SAMPLE_BITS-1:0] last_mean;
   } chan_state_type;

   function automatic logic [TREND_W-1:0] trend_of(input logic [SAMPLE_BITS-1:0] prev,
                                                   input logic [SAMPLE_BITS-1:0] now);
      logic [TREND_W-1:0] code;
      if (now > prev) begin
         code = TREND_ROSE;
      end else if (now < prev) begin
         code = TREND_FELL;
      end else begin
         code = TREND_EQUAL;
      end
      return code;
   endfunction

endpackage

[rtl/core/mmat_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mmat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/multichannel_moving_average_trend_core.sv]
// Top level of the multichannel moving average core with trend codes.
`timescale 1ns / 1ps

// Each beat on req carries a channel and an unsigned Q16.16 sample; one beat
// on rsp comes back with the sample, the truncated mean of it and up to four
// earlier samples of that channel, and rise/fall/equal codes against the
// previous sample and mean. Items are handled one at a time: an in-range
// item goes through one state read, four history reads through the single
// history read port, a 7-bit-per-cycle divider and one write-back, which
// waits while an earlier result is still held, before the next acceptance;
// its result is registered at the write-back. A channel at or above
// CHANNELS is dropped with no result. The output register lets the next
// item start while a result waits. Per-channel state clears at reset through
// valid bits, so there is no clearing pass.
module multichannel_moving_average_trend_core #(
   parameter int CHANNELS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mmat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mmat_pkg::rsp_type rsp_data
);

   import mmat_pkg::*;

   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_DEPTH = 1 << CH_W;
   localparam int ST_W     = $bits(chan_state_type);

   localparam logic [2:0] SUM_LAST = 3'(WIN_SLOTS - 1);
   localparam logic [2:0] DIV_LAST = 3'(DIV_CYCLES - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SUM   = 5'b00100,
      S_DIV   = 5'b01000,
      S_WRITE = 5'b10000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   logic [CHANNEL_W-1:0]   chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SUM_W-1:0]       quot_ff, quot_in;
   logic [2:0]             rem_ff, rem_in;
   logic [2:0]             divisor_ff, divisor_in;
   logic                   hit_ff, hit_in;
   logic [CH_DEPTH-1:0]    valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [CH_W-1:0]        ch_addr;
   logic                   in_range;
   logic                   fire;
   logic [ST_W-1:0]        st_rd_raw;
   chan_state_type         st_rd, st_now, st_wr;
   logic [SAMPLE_BITS-1:0] hist_rd;
   logic [SLOT_W-1:0]      hist_slot;
   logic                   hist_rd_en;
   logic [2:0]             stored;
   logic [SAMPLE_BITS-1:0] mean;
   logic [2:0]             div_rem;
   logic [SUM_W-1:0]       div_quot;

   assign ch_addr   = CH_W'(chan_ff);
   assign in_range  = int'(req_data.channel) < CHANNELS;
   assign req_ready = (state_ff == S_IDLE);
   assign fire      = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_ready);

   // A channel never written since reset reads as all zero.
   assign st_rd  = chan_state_type'(st_rd_raw);
   assign st_now = hit_ff ? st_rd : '0;
   assign stored = (st_now.fill > 3'(WIN_SLOTS)) ? 3'(WIN_SLOTS) : st_now.fill;
   assign mean   = quot_ff[SAMPLE_BITS-1:0];

   assign hist_slot  = (state_ff == S_READ) ? '0 : SLOT_W'(cnt_ff + 3'd1);
   assign hist_rd_en = (state_ff == S_READ) || ((state_ff == S_SUM) && (cnt_ff != SUM_LAST));

   always_comb begin
      st_wr             = st_now;
      st_wr.fill        = (st_now.fill < 3'(WIN_SIZE)) ? st_now.fill + 3'd1 : st_now.fill;
      st_wr.slot        = st_now.slot + SLOT_W'(1);
      st_wr.last_sample = sample_ff;
      st_wr.last_mean   = mean;
   end

   // Restoring division by 1..5: the remainder stays below the divisor.
   always_comb begin
      logic [2:0] r;
      logic [3:0] t;
      logic [SUM_W-1:0] q;
      r = rem_ff;
      q = quot_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         t = {r, sum_ff[SUM_W-1-i]};
         if (t >= {1'b0, divisor_ff}) begin
            r = 3'(t - {1'b0, divisor_ff});
            q = {q[SUM_W-2:0], 1'b1};
         end else begin
            r = t[2:0];
            q = {q[SUM_W-2:0], 1'b0};
         end
      end
      div_rem  = r;
      div_quot = q;
   end

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      sample_in    = sample_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      hit_in       = hit_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && in_range) begin
               chan_in   = req_data.channel;
               sample_in = req_data.sample;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            hit_in   = valid_ff[ch_addr];
            sum_in   = SUM_W'(sample_ff);
            cnt_in   = '0;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (cnt_ff < stored) begin
               sum_in = sum_ff + SUM_W'(hist_rd);
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == SUM_LAST) begin
               divisor_in = stored + 3'd1;
               quot_in    = '0;
               rem_in     = '0;
               cnt_in     = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            quot_in = div_quot;
            rem_in  = div_rem;
            sum_in  = sum_ff << DIV_STEP;
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (fire) begin
               valid_in[ch_addr]        = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_data_in.channel_out  = chan_ff;
               rsp_data_in.latest       = sample_ff;
               rsp_data_in.mean         = mean;
               rsp_data_in.sample_trend = trend_of(st_now.last_sample, sample_ff);
               rsp_data_in.mean_trend   = trend_of(st_now.last_mean, mean);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
      end
      chan_ff     <= chan_in;
      sample_ff   <= sample_in;
      sum_ff      <= sum_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-channel counters and last values. Items never overlap, so the
   // write-back lands before the next read of any entry.
   mmat_ram #(
      .WIDTH (ST_W),
      .DEPTH (CH_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr (ch_addr),
      .wr_data (ST_W'(st_wr)),
      .rd_en   (state_ff == S_READ),
      .rd_addr (ch_addr),
      .rd_data (st_rd_raw)
   );

   // Four history slots per channel.
   mmat_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (CH_DEPTH * WIN_SLOTS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (fire),
      .wr_addr ({ch_addr, st_now.slot}),
      .wr_data (sample_ff),
      .rd_en   (hist_rd_en),
      .rd_addr ({ch_addr, hist_slot}),
      .rd_data (hist_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/mmat_checker.sv]
// Port-level checks for the multichannel moving average core, with its bind.
`timescale 1ns / 1ps

module mmat_checker #(
   parameter int CHANNELS = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mmat_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mmat_pkg::rsp_type rsp_data
);

   import mmat_pkg::*;

   // Nothing is on the result side right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // An in-range item keeps the core busy for the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (int'(req_data.channel) < CHANNELS)) |=> !req_ready)
      else $error("core ready again right after taking an item");

   // Trend codes carry only equal, rose or fell.
   a_trend_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.sample_trend == TREND_EQUAL ||
                      rsp_data.sample_trend == TREND_ROSE ||
                      rsp_data.sample_trend == TREND_FELL) &&
                     (rsp_data.mean_trend == TREND_EQUAL ||
                      rsp_data.mean_trend == TREND_ROSE ||
                      rsp_data.mean_trend == TREND_FELL)))
      else $error("bad trend code on result beat");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat changed while stalled");

endmodule

bind multichannel_moving_average_trend_core mmat_checker #(
   .CHANNELS (CHANNELS)
) u_mmat_checker (.*);

[tb/mmat_average_checker.sv]
// Checker for the moving average core: predicts each result and compares it.
`timescale 1ns / 1ps

module mmat_average_checker #(
   parameter int CHANNELS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  mmat_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  mmat_pkg::rsp_type rsp_data,
   output int                failures,
   output int                pending
);
   import mmat_pkg::*;

   logic [SAMPLE_BITS-1:0] window      [CHANNELS][WIN_SLOTS];
   logic [FILL_W-1:0]      seen        [CHANNELS];
   logic [SLOT_W-1:0]      next_slot   [CHANNELS];
   logic [SAMPLE_BITS-1:0] prev_sample [CHANNELS];
   logic [SAMPLE_BITS-1:0] prev_mean   [CHANNELS];
   rsp_type                pending_means[$];

   function automatic logic [TREND_W-1:0] level_change(input logic [SAMPLE_BITS-1:0] was,
                                                       input logic [SAMPLE_BITS-1:0] now);
      if (now > was) begin
         return TREND_ROSE;
      end else if (now < was) begin
         return TREND_FELL;
      end
      return TREND_EQUAL;
   endfunction

   // Out-of-range channels are dropped: no state change, no result.
   task automatic predict_window_mean(input req_type beat);
      int                     ch;
      int                     held;
      logic [SUM_W-1:0]       total;
      logic [SUM_W-1:0]       count;
      logic [SAMPLE_BITS-1:0] avg;
      rsp_type                want;
      ch = int'(beat.channel);
      if (ch >= CHANNELS) begin
         return;
      end
      held  = (seen[ch] > WIN_SLOTS) ? WIN_SLOTS : int'(seen[ch]);
      total = SUM_W'(beat.sample);
      for (int i = 0; i < held; i++) begin
         total = total + SUM_W'(window[ch][i]);
      end
      count = SUM_W'(held + 1);
      avg   = SAMPLE_BITS'(total / count);
      want.channel_out  = beat.channel;
      want.latest       = beat.sample;
      want.mean         = avg;
      want.sample_trend = level_change(prev_sample[ch], beat.sample);
      want.mean_trend   = level_change(prev_mean[ch], avg);
      pending_means.push_back(want);
      window[ch][next_slot[ch]] = beat.sample;
      next_slot[ch] = next_slot[ch] + 1'b1;
      if (seen[ch] < WIN_SIZE) begin
         seen[ch] = seen[ch] + 1'b1;
      end
      prev_sample[ch] = beat.sample;
      prev_mean[ch]   = avg;
   endtask

   task automatic flag(input string field, input logic [SAMPLE_BITS-1:0] want,
                       input logic [SAMPLE_BITS-1:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            seen[c]        = '0;
            next_slot[c]   = '0;
            prev_sample[c] = '0;
            prev_mean[c]   = '0;
         end
         pending_means.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_means.size() == 0) begin
               failures++;
               $display("%0t: unexpected result beat, expected none, got %0h",
                        $time, rsp_data);
            end else begin
               want = pending_means.pop_front();
               if (rsp_data.channel_out !== want.channel_out)
                  flag("channel_out", SAMPLE_BITS'(want.channel_out),
                       SAMPLE_BITS'(rsp_data.channel_out));
               if (rsp_data.latest !== want.latest)
                  flag("latest", want.latest, rsp_data.latest);
               if (rsp_data.mean !== want.mean)
                  flag("mean", want.mean, rsp_data.mean);
               if (rsp_data.sample_trend !== want.sample_trend)
                  flag("sample_trend", SAMPLE_BITS'(want.sample_trend),
                       SAMPLE_BITS'(rsp_data.sample_trend));
               if (rsp_data.mean_trend !== want.mean_trend)
                  flag("mean_trend", SAMPLE_BITS'(want.mean_trend),
                       SAMPLE_BITS'(rsp_data.mean_trend));
            end
         end
         if (req_valid && req_ready) begin
            predict_window_mean(req_data);
         end
      end
      pending = pending_means.size();
   end

endmodule

[tb/multichannel_moving_average_trend_core_test.sv]
// Top of the moving average core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module multichannel_moving_average_trend_core_test;
   import mmat_pkg::*;

   localparam int CHANNELS  = 16;
   localparam int ITEMS     = 1450;
   localparam int LIMIT     = 400000;
   localparam int HOLD_OFF  = 400;
   localparam int HOLD_AT   = 3000;
   localparam int DRAIN     = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycles    = 0;

   logic [SAMPLE_BITS-1:0] last_sent [16];

   multichannel_moving_average_trend_core #(.CHANNELS(CHANNELS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mmat_average_checker #(.CHANNELS(CHANNELS)) checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("** multichannel_moving_average_trend_core: FAILED **");
         $finish;
      end
   end

   function automatic req_type beat_of(input int ch, input logic [SAMPLE_BITS-1:0] value);
      req_type beat;
      beat.channel = CHANNEL_W'(ch);
      beat.sample  = value;
      return beat;
   endfunction

   // Mix of wide random values, small values, values near full scale, values
   // close to the channel's last sample and repeats of it (to hit the equal trend).
   function automatic req_type random_beat();
      int                     ch;
      int                     kind;
      logic [SAMPLE_BITS-1:0] value;
      ch   = $urandom_range(0, 15);
      kind = $urandom_range(0, 9);
      case (kind)
         4, 5: begin
            value = $urandom_range(0, 255) << 16 | $urandom_range(0, 65535);
         end
         6: begin
            value = 32'hFFFF_FFFF - $urandom_range(0, 65535);
         end
         7, 8: begin
            value = last_sent[ch];
         end
         9: begin
            value = last_sent[ch] + $urandom_range(0, 7) - 3;
         end
         default: begin
            value = $urandom;
         end
      endcase
      return beat_of(ch, value);
   endfunction

   task automatic send_beat(input req_type beat);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      last_sent[beat.channel] = beat.sample;
   endtask

   // Sender and verdict.
   initial begin
      req_type plan[$];
      int      sent;
      int      burst;
      int      gap;
      foreach (last_sent[c]) last_sent[c] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan.push_back(beat_of(0, 32'h0000_0000));
      repeat (6) plan.push_back(beat_of(15, 32'hFFFF_FFFF));
      for (int i = 1; i <= 6; i++) plan.push_back(beat_of(3, i * 32'h000A_0000));
      plan.push_back(beat_of(3, 32'h0005_0000));
      plan.push_back(beat_of(3, 32'h0005_0000));
      plan.push_back(beat_of(7, 32'h0001_0000));
      plan.push_back(beat_of(7, 32'h0000_0000));
      plan.push_back(beat_of(7, 32'h8000_0000));
      plan.push_back(beat_of(15, 32'h0000_0000));
      foreach (plan[i]) send_beat(plan[i]);
      sent = plan.size();

      while (sent < ITEMS) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < ITEMS; i++) begin
            send_beat(random_beat());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN) @(posedge clock);
      if (failures == 0) begin
         $display("** multichannel_moving_average_trend_core: PASSED **");
      end else begin
         $display("** multichannel_moving_average_trend_core: FAILED **");
      end
      $finish;
   end

   // Receiver: the stall pattern is redrawn at random from span to span; one
   // long hold-off lets the core back up and drop req_ready.
   initial begin
      int mode;
      int span;
      int count;
      span  = 0;
      count = 0;
      mode  = 0;
      while (reset) @(posedge clock);
      forever begin
         if (count == HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            count += HOLD_OFF;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
         end
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (count % 5 != 0);
         endcase
         span--;
         count++;
         @(posedge clock);
      end
   end

endmodule
